/* rtl/core/icae_pkg.sv */
// ----------------------------------------------------------------------------
// icae_pkg
// Shared types and constants for the formatting-code to terminal-escape
// converter: escape ops, queue entry layout and the colour table.
// ----------------------------------------------------------------------------
`default_nettype none

package icae_pkg;

  localparam int OPS = 3;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_SHORT = 2'd1,   // ESC [ arg m
    OP_COLOR = 2'd2,   // ESC [ tens ones m, arg[3:0] is the table index
    OP_LIT   = 2'd3    // arg as is
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] arg;
  } op_t;

  // ops packed toward index 0; index 0 is emitted first
  typedef op_t [OPS-1:0] entry_t;

  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_M      = 8'h6D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_FOUR   = 8'h34;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [7:0] CTL_COLOR     = 8'h03;
  localparam logic [7:0] CTL_BOLD      = 8'h02;
  localparam logic [7:0] CTL_UNDERLINE = 8'h1F;
  localparam logic [7:0] CTL_RESET     = 8'h0F;
  localparam logic [7:0] CTL_REVERSE   = 8'h16;

  // SGR foreground codes in BCD
  localparam logic [7:0] COLOUR_BCD [16] = '{
    8'h37, 8'h30, 8'h34, 8'h32, 8'h31, 8'h31, 8'h35, 8'h33,
    8'h93, 8'h92, 8'h36, 8'h96, 8'h94, 8'h95, 8'h90, 8'h37
  };

endpackage

`default_nettype wire

/* rtl/core/icae_queue.sv */
// ----------------------------------------------------------------------------
// icae_queue
// Small register FIFO of decoded entries between the parser and the
// escape sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module icae_queue #(
  parameter int DEPTH = 4
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   wr_en,
  input  wire icae_pkg::entry_t wr_data,
  output logic                  full,
  input  wire                   rd_en,
  output icae_pkg::entry_t      rd_data,
  output logic                  empty
);
  import icae_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) rd_en |-> !empty)
    else $error("queue pop while empty");
  assert property (@(posedge clk) disable iff (rst) wr_en |-> !full)
    else $error("queue push while full");
  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count overflow");

endmodule

`default_nettype wire

/* rtl/core/icae_front.sv */
// ----------------------------------------------------------------------------
// icae_front
// Input parser: tracks control/colour/comma state per byte and turns each
// byte into up to three escape ops, pushed as one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module icae_front (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire [7:0]        in_byte,
  input  wire              in_last,
  input  wire              q_full,
  output logic             push,
  output icae_pkg::entry_t entry
);
  import icae_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CTRL  = 6'b000010,
    ST_DIG1  = 6'b000100,
    ST_AFTER = 6'b001000,
    ST_COMMA = 6'b010000,
    ST_BG1   = 6'b100000
  } mode_t;

  mode_t      mode;
  mode_t      mode_next;
  logic [3:0] fg;
  logic [3:0] fg_next;
  logic       accept;

  function automatic op_t colour_op(logic [6:0] val);
    op_t o;
    if (val > 7'd15) begin
      o.kind = OP_SHORT;
      o.arg  = CH_ZERO;
    end else begin
      o.kind = OP_COLOR;
      o.arg  = {4'd0, val[3:0]};
    end
    return o;
  endfunction

  always_comb begin
    logic       is_dig;
    logic [3:0] dval;
    logic       do_plain;
    op_t        raw [OPS];
    logic [1:0] slot;

    is_dig    = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    dval      = in_byte[3:0];
    do_plain  = 1'b0;
    mode_next = mode;
    fg_next   = fg;
    for (int i = 0; i < OPS; i++) begin
      raw[i] = '{kind: OP_NONE, arg: 8'd0};
    end

    unique case (mode)
      ST_CTRL: begin
        if (is_dig) begin
          fg_next   = dval;
          mode_next = ST_DIG1;
        end else begin
          raw[0]   = '{kind: OP_SHORT, arg: CH_ZERO};
          do_plain = 1'b1;
        end
      end
      ST_DIG1: begin
        if (is_dig) begin
          raw[0]    = colour_op(7'(fg) * 7'd10 + 7'(dval));
          mode_next = ST_AFTER;
        end else begin
          raw[0] = colour_op(7'(fg));
          if (in_byte == CH_COMMA) begin
            mode_next = ST_COMMA;
          end else begin
            do_plain = 1'b1;
          end
        end
      end
      ST_AFTER: begin
        if (in_byte == CH_COMMA) begin
          mode_next = ST_COMMA;
        end else begin
          do_plain = 1'b1;
        end
      end
      ST_COMMA: begin
        if (is_dig) begin
          mode_next = ST_BG1;
        end else begin
          raw[0]   = '{kind: OP_LIT, arg: CH_COMMA};
          do_plain = 1'b1;
        end
      end
      ST_BG1: begin
        if (is_dig) begin
          mode_next = ST_IDLE;
        end else begin
          do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    if (do_plain) begin
      mode_next = ST_IDLE;
      priority if (in_byte == CTL_COLOR) begin
        mode_next = ST_CTRL;
      end else if (in_byte == CTL_BOLD) begin
        raw[1] = '{kind: OP_SHORT, arg: CH_ONE};
      end else if (in_byte == CTL_UNDERLINE) begin
        raw[1] = '{kind: OP_SHORT, arg: CH_FOUR};
      end else if (in_byte == CTL_RESET) begin
        raw[1] = '{kind: OP_SHORT, arg: CH_ZERO};
      end else if (in_byte == CTL_REVERSE) begin
        raw[1] = '{kind: OP_SHORT, arg: CH_SEVEN};
      end else begin
        raw[1] = '{kind: OP_LIT, arg: in_byte};
      end
    end

    if (in_last) begin
      if (mode_next == ST_CTRL) begin
        raw[2] = '{kind: OP_SHORT, arg: CH_ZERO};
      end else if (mode_next == ST_DIG1) begin
        raw[2] = colour_op(7'(fg_next));
      end else if (mode_next == ST_COMMA) begin
        raw[2] = '{kind: OP_LIT, arg: CH_COMMA};
      end
      mode_next = ST_IDLE;
    end

    // pack non-empty ops to the front
    entry = '0;
    slot  = 2'd0;
    for (int i = 0; i < OPS; i++) begin
      if (raw[i].kind != OP_NONE) begin
        entry[slot] = raw[i];
        slot        = slot + 2'd1;
      end
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (entry[0].kind != OP_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ST_IDLE;
      fg   <= 4'd0;
    end else if (accept) begin
      mode <= mode_next;
      fg   <= fg_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/icae_back.sv */
// ----------------------------------------------------------------------------
// icae_back
// Escape sequencer: walks the ops of the head queue entry byte by byte into
// a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module icae_back (
  input  wire                   clk,
  input  wire                   rst,
  input  wire icae_pkg::entry_t head,
  input  wire                   q_empty,
  output logic                  pop,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_last
);
  import icae_pkg::*;

  logic [1:0] op_idx;
  logic [2:0] pos;
  op_t        cur;
  op_kind_t   nxt_kind;
  logic [2:0] len;
  logic       op_done;
  logic       last_op;
  logic       load;
  logic [7:0] bcd;
  logic [7:0] byte_next;

  always_comb begin
    unique case (op_idx)
      2'd0:    begin cur = head[0]; nxt_kind = head[1].kind; end
      2'd1:    begin cur = head[1]; nxt_kind = head[2].kind; end
      default: begin cur = head[2]; nxt_kind = OP_NONE;      end
    endcase
  end

  always_comb begin
    unique case (cur.kind)
      OP_SHORT: len = 3'd4;
      OP_COLOR: len = 3'd5;
      default:  len = 3'd1;
    endcase
  end

  assign bcd = COLOUR_BCD[cur.arg[3:0]];

  always_comb begin
    byte_next = cur.arg;
    unique case (cur.kind)
      OP_SHORT: begin
        unique case (pos)
          3'd0:    byte_next = CH_ESC;
          3'd1:    byte_next = CH_LBRACK;
          3'd2:    byte_next = cur.arg;
          default: byte_next = CH_M;
        endcase
      end
      OP_COLOR: begin
        unique case (pos)
          3'd0:    byte_next = CH_ESC;
          3'd1:    byte_next = CH_LBRACK;
          3'd2:    byte_next = {4'h3, bcd[7:4]};
          3'd3:    byte_next = {4'h3, bcd[3:0]};
          default: byte_next = CH_M;
        endcase
      end
      default: byte_next = cur.arg;
    endcase
  end

  assign op_done = (pos == len - 3'd1);
  assign last_op = (nxt_kind == OP_NONE);
  assign load    = !q_empty && (!out_valid || out_ready);
  assign pop     = load && op_done && last_op;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= byte_next;
      out_last <= op_done && last_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      op_idx    <= 2'd0;
      pos       <= 3'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        if (op_done) begin
          pos    <= 3'd0;
          op_idx <= last_op ? 2'd0 : op_idx + 2'd1;
        end else begin
          pos <= pos + 3'd1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) !q_empty |-> (pos < len))
    else $error("byte position beyond op length");
  assert property (@(posedge clk) disable iff (rst) op_idx != 2'd3)
    else $error("op index out of range");
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && !out_ready |=> out_valid)
    else $error("output dropped while stalled");

endmodule

`default_nettype wire

/* rtl/core/irc_color_code_to_ansi_escape.sv */
// ----------------------------------------------------------------------------
// irc_color_code_to_ansi_escape
// Converts chat formatting codes in a byte stream to terminal escapes.
// ----------------------------------------------------------------------------
// Path: an accepted item is written into the entry queue, and the sequencer
//   then loads each result byte into the output register.
// Throughput: one result byte per cycle from the output register while not
//   stalled; an input item is taken every cycle while the entry queue has room,
//   so plain text runs at one byte per cycle and escapes are 4 or 5 bytes long.
// Reset (rst, synchronous): parser back to plain text, queue and output empty.
// ----------------------------------------------------------------------------
`default_nettype none

module irc_color_code_to_ansi_escape #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire        s_axis_tlast,   // msg_last
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // run_last
);
  import icae_pkg::*;

  entry_t wr_entry;
  entry_t rd_entry;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_empty;

  icae_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .q_full   (q_full),
    .push     (push),
    .entry    (wr_entry)
  );

  icae_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (wr_entry),
    .full    (q_full),
    .rd_en   (pop),
    .rd_data (rd_entry),
    .empty   (q_empty)
  );

  icae_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (rd_entry),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the formatting-code to terminal-escape converter.
// A queue-fed driver streams message bytes in; each accepted item runs through
// a local parser model that queues the expected escape/text bytes, and a
// monitor checks every output item against the oldest one. Directed corner
// cases come first, then random messages under three idling phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 100;
  localparam int unsigned DRAIN_CYCLES = 12;

  localparam logic [7:0] K_ESC   = 8'h1B;
  localparam logic [7:0] K_LBR   = 8'h5B;
  localparam logic [7:0] K_M     = 8'h6D;
  localparam logic [7:0] K_COMMA = 8'h2C;
  localparam logic [7:0] K_D0    = 8'h30;
  localparam logic [7:0] K_D1    = 8'h31;
  localparam logic [7:0] K_D4    = 8'h34;
  localparam logic [7:0] K_D7    = 8'h37;
  localparam logic [7:0] K_D9    = 8'h39;

  localparam logic [7:0] C_COLOR = 8'h03;
  localparam logic [7:0] C_BOLD  = 8'h02;
  localparam logic [7:0] C_UL    = 8'h1F;
  localparam logic [7:0] C_RST   = 8'h0F;
  localparam logic [7:0] C_REV   = 8'h16;

  localparam int unsigned FG_SGR [16] = '{
    37, 30, 34, 32, 31, 31, 35, 33, 93, 92, 36, 96, 94, 95, 90, 37
  };

  typedef enum logic [2:0] {
    PM_IDLE, PM_CTRL, PM_DIG1, PM_AFTER, PM_COMMA, PM_BG1
  } parse_mode_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } byte_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic       s_axis_tlast = 1'b0;    // msg_last
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic       m_axis_tlast;           // run_last

  irc_color_code_to_ansi_escape u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  byte_item_t   msg_bytes [$];
  byte_item_t   term_bytes [$];
  logic [7:0]   esc_buf [$];
  parse_mode_t  mode = PM_IDLE;
  logic [3:0]   fg_digit = 4'd0;
  int unsigned  bytes_taken = 0;
  int unsigned  bytes_queued = 0;
  int unsigned  errors = 0;
  int unsigned  cycles = 0;

  // ---- converter model ----
  function automatic bit is_digit(logic [7:0] b);
    return b >= K_D0 && b <= K_D9;
  endfunction

  task automatic emit_sgr(logic [7:0] ch);
    esc_buf.push_back(K_ESC);
    esc_buf.push_back(K_LBR);
    esc_buf.push_back(ch);
    esc_buf.push_back(K_M);
  endtask

  task automatic emit_colour(int unsigned value);
    int unsigned sgr;
    if (value > 15) begin
      emit_sgr(K_D0);
    end else begin
      sgr = FG_SGR[value];
      esc_buf.push_back(K_ESC);
      esc_buf.push_back(K_LBR);
      esc_buf.push_back(K_D0 + 8'(sgr / 10));
      esc_buf.push_back(K_D0 + 8'(sgr % 10));
      esc_buf.push_back(K_M);
    end
  endtask

  task automatic text_byte(logic [7:0] b);
    mode = PM_IDLE;
    case (b)
      C_COLOR: mode = PM_CTRL;
      C_BOLD:  emit_sgr(K_D1);
      C_UL:    emit_sgr(K_D4);
      C_RST:   emit_sgr(K_D0);
      C_REV:   emit_sgr(K_D7);
      default: esc_buf.push_back(b);
    endcase
  endtask

  task automatic comma_or_text(logic [7:0] b);
    if (b == K_COMMA) begin
      mode = PM_COMMA;
    end else begin
      text_byte(b);
    end
  endtask

  task automatic convert_byte(logic [7:0] b, logic last);
    esc_buf.delete();
    case (mode)
      PM_CTRL: begin
        if (is_digit(b)) begin
          fg_digit = 4'(b - K_D0);
          mode = PM_DIG1;
        end else begin
          emit_sgr(K_D0);
          text_byte(b);
        end
      end
      PM_DIG1: begin
        if (is_digit(b)) begin
          emit_colour(int'(fg_digit) * 10 + int'(b - K_D0));
          mode = PM_AFTER;
        end else begin
          emit_colour(fg_digit);
          comma_or_text(b);
        end
      end
      PM_AFTER: comma_or_text(b);
      PM_COMMA: begin
        if (is_digit(b)) begin
          mode = PM_BG1;
        end else begin
          esc_buf.push_back(K_COMMA);
          text_byte(b);
        end
      end
      PM_BG1: begin
        if (is_digit(b)) begin
          mode = PM_IDLE;
        end else begin
          text_byte(b);
        end
      end
      default: text_byte(b);
    endcase
    if (last) begin
      if (mode == PM_CTRL) begin
        emit_sgr(K_D0);
      end else if (mode == PM_DIG1) begin
        emit_colour(fg_digit);
      end else if (mode == PM_COMMA) begin
        esc_buf.push_back(K_COMMA);
      end
      mode = PM_IDLE;
    end
    foreach (esc_buf[k]) begin
      term_bytes.push_back('{b: esc_buf[k], last: (k == esc_buf.size() - 1)});
    end
  endtask

  // ---- stimulus helpers ----
  task automatic queue_byte(logic [7:0] b, logic last);
    msg_bytes.push_back('{b: b, last: last});
    bytes_queued++;
  endtask

  function automatic logic [7:0] rand_digit();
    return K_D0 + 8'($urandom_range(0, 9));
  endfunction

  task automatic queue_rand(logic [7:0] b);
    queue_byte(b, $urandom_range(0, 9) == 0);
  endtask

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch at cycle %0d: %s got %02h want %02h", cycles, what, got, want);
    errors++;
  endtask

  function automatic int unsigned idle_pct(bit sender);
    if (bytes_taken < 55) begin
      return sender ? 31 : 73;
    end else if (bytes_taken < 110) begin
      return sender ? 73 : 31;
    end
    return 0;
  endfunction

  // ---- driver ----
  always @(posedge clk) begin
    byte_item_t nxt;
    logic       v;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        convert_byte(s_axis_tdata, s_axis_tlast);
        bytes_taken++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        v = 1'b0;
        nxt = '0;
        if (msg_bytes.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          nxt = msg_bytes.pop_front();
          v = 1'b1;
        end
        s_axis_tvalid <= v;
        s_axis_tdata  <= nxt.b;
        s_axis_tlast  <= nxt.last;
      end
    end
  end

  // ---- monitor ----
  always @(posedge clk) begin
    byte_item_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (term_bytes.size() == 0) begin
          report_mismatch("unexpected item", m_axis_tdata, 8'h00);
        end else begin
          want = term_bytes.pop_front();
          if (m_axis_tdata !== want.b) begin
            report_mismatch("out_byte", m_axis_tdata, want.b);
          end
          if (m_axis_tlast !== want.last) begin
            report_mismatch("run_last", 8'(m_axis_tlast), 8'(want.last));
          end
        end
      end
      m_axis_tready <= $urandom_range(0, 99) >= idle_pct(1'b0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (msg_bytes.size() > 0 || s_axis_tvalid || term_bytes.size() > 0);
  endtask

  initial begin
    int unsigned kind;
    int unsigned n;
    logic [7:0]  ctl [4];
    ctl = '{C_BOLD, C_UL, C_RST, C_REV};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // plain extremes and the four fixed escapes
    queue_byte(8'h41, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h01, 1'b0);
    queue_byte(C_BOLD, 1'b0);
    queue_byte(C_UL, 1'b0);
    queue_byte(C_RST, 1'b0);
    queue_byte(C_REV, 1'b0);
    // colour 00, background with one digit then text
    queue_byte(C_COLOR, 1'b0);
    queue_byte(K_D0, 1'b0);
    queue_byte(K_D0, 1'b0);
    queue_byte(K_COMMA, 1'b0);
    queue_byte(8'h33, 1'b0);
    queue_byte(8'h77, 1'b0);
    // colour number above 15
    queue_byte(C_COLOR, 1'b0);
    queue_byte(K_D9, 1'b0);
    queue_byte(K_D9, 1'b0);
    // control with no digit, then control, one digit, comma without digit
    queue_byte(C_COLOR, 1'b0);
    queue_byte(C_COLOR, 1'b0);
    queue_byte(K_D7, 1'b0);
    queue_byte(K_COMMA, 1'b0);
    queue_byte(8'h7A, 1'b0);
    // one digit then text
    queue_byte(C_COLOR, 1'b0);
    queue_byte(8'h35, 1'b0);
    queue_byte(8'h71, 1'b0);
    // flushes on last
    queue_byte(C_COLOR, 1'b1);
    queue_byte(C_COLOR, 1'b0);
    queue_byte(8'h38, 1'b1);
    queue_byte(C_COLOR, 1'b0);
    queue_byte(K_D1, 1'b0);
    queue_byte(8'h32, 1'b0);
    queue_byte(K_COMMA, 1'b1);

    // hold off until the converter has emptied completely
    wait_drained();

    n = bytes_queued + RANDOM_ITEMS;
    while (bytes_queued < n) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        queue_rand(C_COLOR);
        case ($urandom_range(0, 2))
          1: queue_rand(rand_digit());
          2: begin
            queue_rand($urandom_range(0, 2) != 0 ? K_D0 + 8'($urandom_range(0, 1))
                                                 : rand_digit());
            queue_rand(rand_digit());
          end
          default: ;
        endcase
        if ($urandom_range(0, 1) == 1) begin
          queue_rand(K_COMMA);
          repeat ($urandom_range(0, 2)) queue_rand(rand_digit());
        end
      end else if (kind == 4) begin
        queue_rand(ctl[$urandom_range(0, 3)]);
      end else if (kind <= 7) begin
        repeat ($urandom_range(1, 4)) queue_rand(8'($urandom_range(1, 255)));
      end else if (kind == 8) begin
        queue_rand($urandom_range(0, 1) ? K_COMMA : rand_digit());
      end else begin
        queue_rand(8'($urandom_range(1, 255)));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && term_bytes.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* irc_color_code_to_ansi_escape.f */
rtl/core/icae_pkg.sv
rtl/core/icae_queue.sv
rtl/core/icae_front.sv
rtl/core/icae_back.sv
rtl/core/irc_color_code_to_ansi_escape.sv
dv/tb.sv
